@@ hdl/mcspg_pkg.sv @@
package mcspg_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PIN_W = 4;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_ADD_MOVE = 3'd1;
  localparam logic [2:0] OP_STOP     = 3'd2;
  localparam logic [2:0] OP_SET_POS  = 3'd3;
  localparam logic [2:0] OP_SET_EN   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_UNCONF = 2'd2;

  localparam logic [1:0] CFG_CONFIGURED = 2'd0;
  localparam logic [1:0] CFG_INV_STEP   = 2'd1;
  localparam logic [1:0] CFG_INV_DIR    = 2'd2;
  localparam logic [1:0] CFG_INV_EN     = 2'd3;

  typedef enum logic [1:0] {U_TICK, U_SCAN, U_MOVE} unit_mode_t;

  typedef struct packed {
    logic [31:0] position;
    logic        backward;
    logic        enabled;
    logic [31:0] interval;
    logic [31:0] remaining;
    logic [31:0] due;
  } chan_rec_t;

  typedef struct packed {
    logic            wr_pos;
    logic            wr_dir;
    logic            wr_en;
    logic            wr_ivl;
    logic            wr_rem;
    logic            wr_due;
    logic [CH_W-1:0] idx;
  } chan_wr_t;

  typedef struct packed {
    logic        fire;
    logic        pulse;
    logic        take;
    logic [31:0] pos_next;
    logic [31:0] rem_next;
    logic [31:0] due_next;
  } unit_res_t;

  // channels 4 and up have no register bits
  function automatic logic mask_bit(input logic [3:0] m, input logic [2:0] c);
    return (c < 3'd4) ? m[c[1:0]] : 1'b0;
  endfunction

endpackage

@@ hdl/multi_channel_step_pulse_generator_unit.sv @@
// Step/dir pulse generator for CHANNELS stepper channels. Each item is one
// operation (tick, add move, stop, set position, set enable) and yields one
// result. The block works on one item at a time: a shared 32-bit add and
// compare unit visits the channels one per cycle. A tick makes one pass to
// step the channels and one pass to find the earliest due time; other
// operations make their channel write and then the scan pass. A waiting
// result holds the block until it is taken. The next item is accepted
// once the result sits in the output register. Configuration writes land at
// once and belong to idle periods.
module multi_channel_step_pulse_generator_unit import mcspg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [2:0]  channel,
  input  logic [31:0] now_time,
  input  logic [31:0] move_interval,
  input  logic [31:0] step_count,
  input  logic        direction,
  input  logic signed [31:0] position_value,
  input  logic        enable_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  step_mask,
  output logic [3:0]  dir_pin_levels,
  output logic [3:0]  enable_pin_levels,
  output logic signed [31:0] position_out,
  output logic        moving,
  output logic [31:0] wake_time,
  output logic        wake_valid,
  output logic [1:0]  status
);

  typedef enum logic [2:0] {S_IDLE, S_OP, S_TICK, S_SCAN, S_PUSH} state_t;

  state_t state;
  logic [3:0] configured_mask, invert_step_mask, invert_dir_mask, invert_enable_mask;

  logic [2:0]  op;
  logic [2:0]  ch;
  logic [31:0] now, ivl, cnt, pos;
  logic        dir, en;
  logic [1:0]  stat;
  logic        in_range;
  logic [CH_W-1:0] idx;
  logic [CHANNELS-1:0] steps;
  logic [31:0] wake;
  logic        wake_v;
  logic [31:0] pos_cap;
  logic        moving_cap;

  logic        ch_in_range, ch_configured;
  logic [1:0]  stat_next;
  logic [CH_W-1:0] ch_idx;
  logic        last;

  chan_wr_t    wr;
  chan_rec_t   wdata, rec;
  unit_res_t   res;
  unit_mode_t  mode;
  logic [CHANNELS-1:0] backward_vec, enabled_vec;
  logic [3:0]  dir_lv, en_lv, step_lv;

  assign in_ready = (state == S_IDLE);
  assign ch_idx = ch[CH_W-1:0];
  assign last = (idx == CH_W'(CHANNELS - 1));

  // status of an incoming item, from the ports and current configuration
  always_comb begin
    ch_in_range = ({1'b0, channel} < 4'(CHANNELS));
    ch_configured = mask_bit(configured_mask, channel);
    stat_next = ST_OK;
    if (!ch_in_range) begin
      if (operation <= OP_SET_EN) stat_next = ST_RANGE;
    end else if ((operation inside {OP_ADD_MOVE, OP_SET_EN}) && !ch_configured) begin
      stat_next = ST_UNCONF;
    end
  end

  always_comb begin
    case (state)
      S_TICK:  mode = U_TICK;
      S_OP:    mode = U_MOVE;
      default: mode = U_SCAN;
    endcase
  end

  mcspg_step_unit u_step (
    .mode       (mode),
    .rec        (rec),
    .configured (mask_bit(configured_mask, 3'(idx))),
    .now        (now),
    .ivl        (ivl),
    .wake       (wake),
    .wake_valid (wake_v),
    .res        (res)
  );

  // channel writes: tick pass at the visited channel, operations at the item's
  always_comb begin
    wr = '0;
    wdata = '0;
    wr.idx = idx;
    if (state == S_TICK) begin
      wr.wr_pos = res.pulse;
      wr.wr_rem = res.fire;
      wr.wr_due = res.fire;
      wdata.position = res.pos_next;
      wdata.remaining = res.rem_next;
      wdata.due = res.due_next;
    end else if (state == S_OP && stat == ST_OK && in_range) begin
      wr.idx = ch_idx;
      case (op)
        OP_ADD_MOVE: begin
          wr.wr_ivl = 1'b1;
          wr.wr_rem = 1'b1;
          wr.wr_dir = 1'b1;
          wr.wr_due = 1'b1;
          wdata.interval = ivl;
          wdata.remaining = cnt;
          wdata.backward = dir;
          wdata.due = res.due_next;
        end
        OP_STOP: begin
          wr.wr_rem = 1'b1;
          wr.wr_ivl = 1'b1;
        end
        OP_SET_POS: begin
          wr.wr_pos = 1'b1;
          wdata.position = pos;
        end
        OP_SET_EN: begin
          wr.wr_en = 1'b1;
          wdata.enabled = en;
        end
        default: ;
      endcase
    end
  end

  mcspg_chan_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .wdata        (wdata),
    .rd_idx       (idx),
    .rdata        (rec),
    .backward_vec (backward_vec),
    .enabled_vec  (enabled_vec)
  );

  for (genvar i = 0; i < 4; i++) begin : g_pins
    if (i < CHANNELS) begin : g_live
      assign dir_lv[i] = backward_vec[i] ^ invert_dir_mask[i];
      assign en_lv[i] = ~enabled_vec[i] ^ invert_enable_mask[i];
      assign step_lv[i] = steps[i];
    end else begin : g_none
      assign dir_lv[i] = 1'b0;
      assign en_lv[i] = 1'b0;
      assign step_lv[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      configured_mask <= '0;
      invert_step_mask <= '0;
      invert_dir_mask <= '0;
      invert_enable_mask <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CONFIGURED: configured_mask <= cfg_data;
        CFG_INV_STEP:   invert_step_mask <= cfg_data;
        CFG_INV_DIR:    invert_dir_mask <= cfg_data;
        CFG_INV_EN:     invert_enable_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_PUSH) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= operation;
            ch <= channel;
            now <= now_time;
            ivl <= move_interval;
            cnt <= step_count;
            dir <= direction;
            pos <= position_value;
            en <= enable_value;
            stat <= stat_next;
            in_range <= ch_in_range;
            steps <= '0;
            wake <= '0;
            wake_v <= 1'b0;
            pos_cap <= '0;
            moving_cap <= 1'b0;
            idx <= '0;
            state <= (operation == OP_TICK) ? S_TICK : S_OP;
          end
        end
        S_OP: begin
          state <= S_SCAN;
        end
        S_TICK: begin
          if (res.pulse) steps[idx] <= 1'b1;
          idx <= last ? '0 : idx + CH_W'(1);
          if (last) state <= S_SCAN;
        end
        S_SCAN: begin
          if (res.take) begin
            wake <= rec.due;
            wake_v <= 1'b1;
          end
          // pick up the addressed channel as the pass goes by
          if (in_range && idx == ch_idx) begin
            pos_cap <= rec.position;
            moving_cap <= (rec.remaining != 32'd0);
          end
          idx <= last ? '0 : idx + CH_W'(1);
          if (last) state <= S_PUSH;
        end
        S_PUSH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            step_mask <= step_lv;
            dir_pin_levels <= dir_lv;
            enable_pin_levels <= en_lv;
            position_out <= pos_cap;
            moving <= moving_cap;
            wake_time <= wake;
            wake_valid <= wake_v;
            status <= stat;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/mcspg_step_unit.sv @@
module mcspg_step_unit import mcspg_pkg::*; (
  input  unit_mode_t  mode,
  input  chan_rec_t   rec,
  input  logic        configured,
  input  logic [31:0] now,
  input  logic [31:0] ivl,
  input  logic [31:0] wake,
  input  logic        wake_valid,
  output unit_res_t   res
);

  logic [31:0] sub_a, sub_b, diff, add_a, add_b, sum;
  logic        active;

  always_comb begin
    // one subtractor: due check on a tick, earliest-time compare on a scan
    if (mode == U_SCAN) begin
      sub_a = rec.due;
      sub_b = wake;
    end else begin
      sub_a = now;
      sub_b = rec.due;
    end
    diff = sub_a - sub_b;

    if (mode == U_MOVE) begin
      add_a = now;
      add_b = ivl;
    end else begin
      add_a = rec.due;
      add_b = rec.interval;
    end
    sum = add_a + add_b;

    active = (rec.remaining != 32'd0);
    res.fire = active && !diff[31];
    res.pulse = res.fire && configured && rec.enabled;
    res.take = active && (!wake_valid || diff[31]);
    res.pos_next = rec.backward ? (rec.position - 32'd1) : (rec.position + 32'd1);
    res.rem_next = rec.remaining - 32'd1;
    if (mode == U_MOVE) begin
      res.due_next = sum;
    end else if (res.rem_next != 32'd0) begin
      res.due_next = sum;
    end else begin
      res.due_next = rec.due;
    end
  end

endmodule

@@ hdl/mcspg_chan_regs.sv @@
module mcspg_chan_regs import mcspg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  chan_wr_t            wr,
  input  chan_rec_t           wdata,
  input  logic [CH_W-1:0]     rd_idx,
  output chan_rec_t           rdata,
  output logic [CHANNELS-1:0] backward_vec,
  output logic [CHANNELS-1:0] enabled_vec
);

  logic [31:0] position [CHANNELS];
  logic [31:0] interval [CHANNELS];
  logic [31:0] remaining [CHANNELS];
  logic [31:0] due [CHANNELS];
  logic [CHANNELS-1:0] backward;
  logic [CHANNELS-1:0] enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        position[i] <= '0;
        interval[i] <= '0;
        remaining[i] <= '0;
        due[i] <= '0;
      end
      backward <= '0;
      enabled <= '0;
    end else begin
      if (wr.wr_pos) position[wr.idx] <= wdata.position;
      if (wr.wr_dir) backward[wr.idx] <= wdata.backward;
      if (wr.wr_en) enabled[wr.idx] <= wdata.enabled;
      if (wr.wr_ivl) interval[wr.idx] <= wdata.interval;
      if (wr.wr_rem) remaining[wr.idx] <= wdata.remaining;
      if (wr.wr_due) due[wr.idx] <= wdata.due;
    end
  end

  always_comb begin
    rdata.position = position[rd_idx];
    rdata.backward = backward[rd_idx];
    rdata.enabled = enabled[rd_idx];
    rdata.interval = interval[rd_idx];
    rdata.remaining = remaining[rd_idx];
    rdata.due = due[rd_idx];
  end

  assign backward_vec = backward;
  assign enabled_vec = enabled;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import mcspg_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 4 * (2 * CHANNELS + 2);

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  ch;
    logic [31:0] now;
    logic [31:0] ivl;
    logic [31:0] cnt;
    logic        dir;
    logic [31:0] pos;
    logic        en;
  } motion_cmd_t;

  typedef struct packed {
    logic [3:0]  steps;
    logic [3:0]  dirs;
    logic [3:0]  ens;
    logic [31:0] pos;
    logic        moving;
    logic [31:0] wake;
    logic        wake_ok;
    logic [1:0]  status;
  } pin_report_t;

  typedef struct {
    logic        is_cfg;
    logic [1:0]  cfg_idx;
    logic [3:0]  cfg_val;
    motion_cmd_t cmd;
    logic        has_exp;
    pin_report_t exp;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  operation = '0;
  logic [2:0]  channel = '0;
  logic [31:0] now_time = '0;
  logic [31:0] move_interval = '0;
  logic [31:0] step_count = '0;
  logic        direction = 1'b0;
  logic signed [31:0] position_value = '0;
  logic        enable_value = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  step_mask;
  logic [3:0]  dir_pin_levels;
  logic [3:0]  enable_pin_levels;
  logic signed [31:0] position_out;
  logic        moving;
  logic [31:0] wake_time;
  logic        wake_valid;
  logic [1:0]  status;

  multi_channel_step_pulse_generator_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .channel(channel), .now_time(now_time),
    .move_interval(move_interval), .step_count(step_count),
    .direction(direction), .position_value(position_value),
    .enable_value(enable_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .step_mask(step_mask), .dir_pin_levels(dir_pin_levels),
    .enable_pin_levels(enable_pin_levels), .position_out(position_out),
    .moving(moving), .wake_time(wake_time), .wake_valid(wake_valid),
    .status(status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // motion state of the channels as the block should hold it
  logic [31:0] chan_pos  [CHANNELS];
  logic        chan_back [CHANNELS];
  logic        chan_en   [CHANNELS];
  logic [31:0] chan_ivl  [CHANNELS];
  logic [31:0] chan_left [CHANNELS];
  logic [31:0] chan_due  [CHANNELS];
  logic [3:0]  conf_mask = '0;
  logic [3:0]  inv_step_mask = '0;
  logic [3:0]  inv_dir_mask = '0;
  logic [3:0]  inv_en_mask = '0;

  pin_report_t pending_reports [$];
  logic        row_exp_on = 1'b0;
  pin_report_t row_exp = '0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic [31:0] sched_now = '0;
  int unsigned cycle_count = 0;
  int          bad_count = 0;
  int          checked_count = 0;
  int          accepted_count = 0;
  int          pulse_count = 0;
  int          busy_wake_count = 0;
  stim_row_t   script [$];

  initial begin
    for (int k = 0; k < CHANNELS; k++) begin
      chan_pos[k] = '0;
      chan_back[k] = 1'b0;
      chan_en[k] = 1'b0;
      chan_ivl[k] = '0;
      chan_left[k] = '0;
      chan_due[k] = '0;
    end
  end

  function automatic pin_report_t apply_motion_cmd(motion_cmd_t c);
    pin_report_t r;
    logic        in_rng;
    logic        found;
    logic [31:0] gap;
    int          idx;
    r = '0;
    found = 1'b0;
    in_rng = (c.ch < CHANNELS);
    idx = int'(c.ch);
    case (c.op)
      OP_TICK: begin
        for (int k = 0; k < CHANNELS; k++) begin
          gap = c.now - chan_due[k];
          if (chan_left[k] != 0 && !gap[31]) begin
            // count and due time move on even when no pulse goes out
            if (conf_mask[k] && chan_en[k]) begin
              chan_pos[k] = chan_back[k] ? chan_pos[k] - 1 : chan_pos[k] + 1;
              r.steps[k] = 1'b1;
            end
            chan_left[k] = chan_left[k] - 1;
            if (chan_left[k] != 0) chan_due[k] = chan_due[k] + chan_ivl[k];
          end
        end
        if (!in_rng) r.status = ST_RANGE;
      end
      OP_ADD_MOVE, OP_STOP, OP_SET_POS, OP_SET_EN: begin
        if (!in_rng) begin
          r.status = ST_RANGE;
        end else if (c.op == OP_ADD_MOVE) begin
          if (!conf_mask[idx]) begin
            r.status = ST_UNCONF;
          end else begin
            chan_ivl[idx] = c.ivl;
            chan_left[idx] = c.cnt;
            chan_back[idx] = c.dir;
            chan_due[idx] = c.now + c.ivl;
          end
        end else if (c.op == OP_STOP) begin
          chan_left[idx] = '0;
          chan_ivl[idx] = '0;
        end else if (c.op == OP_SET_POS) begin
          chan_pos[idx] = c.pos;
        end else begin
          if (!conf_mask[idx]) r.status = ST_UNCONF;
          else chan_en[idx] = c.en;
        end
      end
      default: ;
    endcase
    for (int k = 0; k < CHANNELS; k++) begin
      r.dirs[k] = chan_back[k] ^ inv_dir_mask[k];
      r.ens[k] = ~chan_en[k] ^ inv_en_mask[k];
      if (chan_left[k] != 0) begin
        gap = chan_due[k] - r.wake;
        // lower channel keeps a tie
        if (!found || gap[31]) r.wake = chan_due[k];
        found = 1'b1;
      end
    end
    r.wake_ok = found;
    if (in_rng) begin
      r.pos = chan_pos[idx];
      r.moving = (chan_left[idx] != 0);
    end
    return r;
  endfunction

  task automatic flag_error(string what, pin_report_t want, pin_report_t got);
    bad_count++;
    if (bad_count <= 10) begin
      $display("error at cycle %0d: %s", cycle_count, what);
      $display("  expected steps %h dirs %h ens %h pos %h moving %b wake %h/%b status %0d",
               want.steps, want.dirs, want.ens, want.pos, want.moving, want.wake,
               want.wake_ok, want.status);
      $display("  actual   steps %h dirs %h ens %h pos %h moving %b wake %h/%b status %0d",
               got.steps, got.dirs, got.ens, got.pos, got.moving, got.wake,
               got.wake_ok, got.status);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin : monitor
    pin_report_t got;
    pin_report_t want;
    pin_report_t model;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = {step_mask, dir_pin_levels, enable_pin_levels, position_out, moving,
               wake_time, wake_valid, status};
        if (pending_reports.size() == 0) begin
          flag_error("result with no item outstanding", '0, got);
        end else begin
          want = pending_reports.pop_front();
          checked_count++;
          if (got !== want) flag_error("result mismatch", want, got);
        end
      end
      if (in_valid && in_ready) begin
        model = apply_motion_cmd({operation, channel, now_time, move_interval, step_count,
                                  direction, position_value, enable_value});
        pending_reports.push_back(row_exp_on ? row_exp : model);
        accepted_count++;
        pulse_count += $countones(model.steps);
        if (model.wake_ok) busy_wake_count++;
      end
    end
  end

  // all driver tasks start and end at a falling edge
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    wait_drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_CONFIGURED: conf_mask = val;
      CFG_INV_STEP:   inv_step_mask = val;
      CFG_INV_DIR:    inv_dir_mask = val;
      default:        inv_en_mask = val;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_cmd(motion_cmd_t c, logic has, pin_report_t e);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    {operation, channel, now_time, move_interval, step_count, direction, position_value,
     enable_value} <= c;
    row_exp_on <= has;
    row_exp <= e;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic stim_row_t item_row(logic [2:0] op, logic [2:0] ch, logic [31:0] now,
                                         logic [31:0] ivl, logic [31:0] cnt, logic dir,
                                         logic [31:0] pos, logic en);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.cfg_idx = '0;
    r.cfg_val = '0;
    r.cmd = {op, ch, now, ivl, cnt, dir, pos, en};
    r.has_exp = 1'b0;
    r.exp = '0;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [1:0] idx, logic [3:0] val);
    stim_row_t r;
    r = item_row(OP_TICK, '0, '0, '0, '0, 1'b0, '0, 1'b0);
    r.is_cfg = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  // typed result: no steps, forward pins, nothing moving
  function automatic stim_row_t typed(stim_row_t r, logic [3:0] ens, logic [31:0] pos,
                                      logic [1:0] st);
    r.has_exp = 1'b1;
    r.exp = '0;
    r.exp.ens = ens;
    r.exp.pos = pos;
    r.exp.status = st;
    return r;
  endfunction

  function automatic motion_cmd_t random_cmd();
    motion_cmd_t c;
    int unsigned r;
    c.now = $urandom;
    c.ivl = $urandom;
    c.cnt = $urandom;
    c.dir = 1'($urandom_range(1));
    c.pos = $urandom;
    c.en = 1'($urandom_range(1));
    c.ch = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 4)) : 3'($urandom_range(3));
    r = $urandom_range(99);
    if (r < 45) begin
      c.op = OP_TICK;
      // mostly a steadily advancing clock, now and then a wild time
      if ($urandom_range(19) != 0) begin
        sched_now = sched_now + $urandom_range(12);
        c.now = sched_now;
      end
    end else if (r < 65) begin
      c.op = OP_ADD_MOVE;
      c.now = sched_now;
      case ($urandom_range(9))
        0: c.ivl = '0;
        1: ;
        default: c.ivl = $urandom_range(15, 1);
      endcase
      case ($urandom_range(9))
        0: c.cnt = '0;
        1: ;
        2: c.cnt = $urandom_range(40, 9);
        default: c.cnt = $urandom_range(8, 1);
      endcase
    end else if (r < 73) begin
      c.op = OP_STOP;
    end else if (r < 81) begin
      c.op = OP_SET_POS;
      if ($urandom_range(1)) c.pos = 32'($urandom_range(20)) - 32'd10;
    end else if (r < 93) begin
      c.op = OP_SET_EN;
      c.en = ($urandom_range(3) != 0);
    end else begin
      c.op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    end
    return c;
  endfunction

  initial begin : stimulus
    stim_row_t row;
    motion_cmd_t c;

    // at reset every channel is unconfigured, disabled and idle
    script.push_back(typed(item_row(OP_TICK, 3'd0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0),
                           4'hF, 32'h0, ST_OK));
    script.push_back(typed(item_row(OP_ADD_MOVE, 3'd0, 32'd10, 32'd5, 32'd3, 1'b0, 32'h0,
                                    1'b0), 4'hF, 32'h0, ST_UNCONF));
    script.push_back(typed(item_row(OP_SET_EN, 3'd1, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b1),
                           4'hF, 32'h0, ST_UNCONF));
    script.push_back(typed(item_row(OP_SET_POS, 3'd2, 32'h0, 32'h0, 32'h0, 1'b0,
                                    32'h7FFF_FFFF, 1'b0), 4'hF, 32'h7FFF_FFFF, ST_OK));
    script.push_back(typed(item_row(OP_SET_POS, 3'd3, 32'h0, 32'h0, 32'h0, 1'b1,
                                    32'h8000_0000, 1'b1), 4'hF, 32'h8000_0000, ST_OK));
    script.push_back(typed(item_row(OP_STOP, 3'd5, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0),
                           4'hF, 32'h0, ST_RANGE));
    script.push_back(typed(item_row(OP_SPARE_HI, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1),
                           4'hF, 32'h0, ST_OK));
    script.push_back(typed(item_row(OP_TICK, 3'd4, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0,
                                    1'b0), 4'hF, 32'h0, ST_RANGE));
    script.push_back(cfg_row(CFG_CONFIGURED, 4'hF));
    script.push_back(cfg_row(CFG_INV_STEP, 4'h0));
    script.push_back(cfg_row(CFG_INV_DIR, 4'hF));
    script.push_back(cfg_row(CFG_INV_EN, 4'h0));
    script.push_back(item_row(OP_SET_EN, 3'd0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b1));
    script.push_back(item_row(OP_SET_EN, 3'd3, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b1));
    script.push_back(item_row(OP_ADD_MOVE, 3'd0, 32'd100, 32'd10, 32'd3, 1'b0, 32'h0, 1'b0));
    // due time wraps past zero
    script.push_back(item_row(OP_ADD_MOVE, 3'd3, 32'hFFFF_FFF0, 32'h20, 32'd2, 1'b1, 32'h0,
                              1'b0));
    script.push_back(item_row(OP_ADD_MOVE, 3'd1, 32'd100, 32'd5, 32'd0, 1'b1, 32'h0, 1'b0));
    // disabled channel: count drops, position holds
    script.push_back(item_row(OP_ADD_MOVE, 3'd2, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                              32'h0, 1'b0));
    script.push_back(item_row(OP_TICK, 3'd0, 32'd110, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0));
    script.push_back(item_row(OP_TICK, 3'd3, 32'h10, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0));
    script.push_back(item_row(OP_TICK, 3'd3, 32'h30, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0));
    script.push_back(item_row(OP_TICK, 3'd0, 32'd120, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0));
    script.push_back(item_row(OP_STOP, 3'd2, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0));
    script.push_back(item_row(OP_TICK, 3'd6, 32'd130, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0));
    script.push_back(cfg_row(CFG_CONFIGURED, 4'h0));
    script.push_back(cfg_row(CFG_INV_STEP, 4'hF));
    script.push_back(cfg_row(CFG_INV_DIR, 4'h0));
    script.push_back(cfg_row(CFG_INV_EN, 4'hF));
    script.push_back(item_row(OP_TICK, 3'd0, 32'd300, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0));
    script.push_back(item_row(OP_ADD_MOVE, 3'd1, 32'd300, 32'd2, 32'd4, 1'b0, 32'h0, 1'b0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    tx_idle_pct = 22;
    rx_idle_pct = 63;
    foreach (script[i]) begin
      row = script[i];
      if (row.is_cfg) write_reg(row.cfg_idx, row.cfg_val);
      else push_cmd(row.cmd, row.has_exp, row.exp);
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 22;
          rx_idle_pct = 63;
          write_reg(CFG_CONFIGURED, 4'hF);
          write_reg(CFG_INV_STEP, 4'($urandom));
          write_reg(CFG_INV_DIR, 4'($urandom));
          write_reg(CFG_INV_EN, 4'($urandom));
          sched_now = 32'hFFFF_FF00;
        end
        1: begin
          tx_idle_pct = 63;
          rx_idle_pct = 22;
          write_reg(CFG_CONFIGURED, 4'($urandom));
          write_reg(CFG_INV_STEP, 4'($urandom));
          write_reg(CFG_INV_DIR, 4'($urandom));
          write_reg(CFG_INV_EN, 4'($urandom));
          sched_now = $urandom;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          write_reg(CFG_CONFIGURED, 4'hF);
          write_reg(CFG_INV_STEP, 4'hF);
          write_reg(CFG_INV_DIR, 4'hF);
          write_reg(CFG_INV_EN, 4'h0);
          sched_now = $urandom;
        end
      endcase
      for (int n = 0; n < 180; n++) begin
        // hold off until the block has handed back everything
        if (ph == 0 && n == 90) wait_drain();
        c = random_cmd();
        push_cmd(c, 1'b0, '0);
      end
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("summary: %0d items sent, %0d results checked, %0d step pulses predicted",
             accepted_count, checked_count, pulse_count);
    $display("summary: %0d results with a channel in motion, %0d errors",
             busy_wake_count, bad_count);
    if (bad_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
